FILE: rtl/u2a_pkg.sv
// u2a_pkg: shared types, constants and the transliteration table
// used by the decode and output stages of the utf-8 to ascii block
package u2a_pkg;

    localparam logic [7:0] NoMap = 8'h2E;

    typedef struct packed {
        logic [3:0]      cnt;
        logic [3:0][7:0] chars;
    } expand_t;

    function automatic logic [2:0] lead_slot(input logic [7:0] b);
        case (b)
            8'hC3: lead_slot = 3'd0;
            8'hC4: lead_slot = 3'd1;
            8'hC5: lead_slot = 3'd2;
            8'hCE: lead_slot = 3'd3;
            8'hCF: lead_slot = 3'd4;
            8'hD0: lead_slot = 3'd5;
            8'hD1: lead_slot = 3'd6;
            default: lead_slot = 3'd7;
        endcase
    endfunction

    localparam string Map0 =
        "AAAAAA.CEEEEIIIIDNOOOOO.OUUUUY..aaaaaa.ceeeeiiiidnooooo.ouuuuy.y";
    localparam string Map1 =
        "AaAaAaCcCcCcCcDdDdEeEeEeEeEeGgGgGgGgHhHhIiIiIiIiIi..JjKk.LlLlLl.";
    localparam string Map2 =
        "LlLlNnNnNn.NnOoOoo..RrRrRrSsSsSsSsTtTtTtUuUuUuUuUuUuWwYyYZzZzZz.";
    localparam string Map3 =
        ".................ABGDEZI.IKLMNXOPR.STYF..O.......abgdezi.iklmnxo";
    localparam string Map4 =
        "prssty...o......................................................";
    localparam string Map5 =
        "................ABVGDE.ZIIKLMNOPRSTUF......Y.E..abvgde.ziiklmnop";
    localparam string Map6 =
        "rstuf......y.e..Ee..............................................";

    function automatic logic [7:0] single_map(input logic [2:0] s, input logic [5:0] i);
        case (s)
            3'd0: single_map = 8'(Map0[i]);
            3'd1: single_map = 8'(Map1[i]);
            3'd2: single_map = 8'(Map2[i]);
            3'd3: single_map = 8'(Map3[i]);
            3'd4: single_map = 8'(Map4[i]);
            3'd5: single_map = 8'(Map5[i]);
            3'd6: single_map = 8'(Map6[i]);
            default: single_map = NoMap;
        endcase
    endfunction

    function automatic expand_t txt2(input logic [7:0] a, input logic [7:0] b);
        expand_t e;
        e.cnt   = 4'd2;
        e.chars = {8'h00, 8'h00, b, a};
        return e;
    endfunction

    // cnt 15 marks no entry
    function automatic expand_t look_up(input logic [7:0] lead, input logic [7:0] nxt);
        expand_t e;
        logic [2:0] s;
        logic [7:0] ch;
        s = lead_slot(lead);
        e.cnt = 4'hF;
        e.chars = '0;
        if (s != 3'd7 && nxt[7:6] == 2'b10) begin
            case ({lead, nxt})
                16'hC386: e = txt2("A", "E");
                16'hC3A6: e = txt2("a", "e");
                16'hC39F: e = txt2("s", "s");
                16'hC4B2: e = txt2("I", "J");
                16'hC4B3: e = txt2("i", "j");
                16'hC592: e = txt2("O", "E");
                16'hC593: e = txt2("o", "e");
                16'hD096: e = txt2("Z", "h");
                16'hD0A5: e = txt2("K", "h");
                16'hD0A6: e = txt2("T", "s");
                16'hD0A7: e = txt2("C", "h");
                16'hD0A8: e = txt2("S", "h");
                16'hD0A9: begin
                    e.cnt = 4'd4;
                    e.chars = {"h", "c", "h", "S"};
                end
                16'hD0AE: e = txt2("Y", "u");
                16'hD0AF: e = txt2("Y", "a");
                16'hD0B6: e = txt2("z", "h");
                16'hD185: e = txt2("k", "h");
                16'hD186: e = txt2("t", "s");
                16'hD187: e = txt2("c", "h");
                16'hD188: e = txt2("s", "h");
                16'hD189: begin
                    e.cnt = 4'd4;
                    e.chars = {"h", "c", "h", "s"};
                end
                16'hD18E: e = txt2("y", "u");
                16'hD18F: e = txt2("y", "a");
                16'hCE98: e = txt2("T", "h");
                16'hCEA7: e = txt2("C", "h");
                16'hCEA8: e = txt2("P", "s");
                16'hCEB8: e = txt2("t", "h");
                16'hCF86: e = txt2("p", "h");
                16'hCF87: e = txt2("c", "h");
                16'hCF88: e = txt2("p", "s");
                16'hD0AA, 16'hD0AC, 16'hD18A, 16'hD18C: e.cnt = 4'd0;
                default: begin
                    ch = single_map(s, nxt[5:0]);
                    if (ch != NoMap) begin
                        e.cnt = 4'd1;
                        e.chars = {24'h0, ch};
                    end
                end
            endcase
        end
        return e;
    endfunction

endpackage

FILE: rtl/u2a_decode.sv
// u2a_decode: input register, lead hold and table lookup for one byte
// depends on u2a_pkg
module u2a_decode (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [7:0]       in_byte,
    input  logic             in_final,
    output logic             grp_valid,
    input  logic             grp_ready,
    output u2a_pkg::expand_t grp
);
    import u2a_pkg::*;

    logic       pend_reg, pend_next;
    logic [7:0] held_reg, held_next;
    logic       gv_reg, gv_next;
    expand_t    grp_reg, grp_next;
    expand_t    lk;
    logic       take;

    assign in_ready  = !gv_reg || grp_ready;
    assign take      = in_valid && in_ready;
    assign grp_valid = gv_reg;
    assign grp       = grp_reg;

    always_comb begin
        lk = look_up(held_reg, in_byte);
        pend_next = pend_reg;
        held_next = held_reg;
        gv_next   = gv_reg && !grp_ready;
        grp_next  = grp_reg;
        if (take) begin
            grp_next.cnt = 4'd0;
            grp_next.chars = '0;
            if (pend_reg && lk.cnt != 4'hF) begin
                grp_next = lk;
                pend_next = 1'b0;
                held_next = 8'h00;
            end else begin
                if (pend_reg) begin
                    grp_next.cnt = 4'd1;
                    grp_next.chars[0] = held_reg;
                end
                if (lead_slot(in_byte) != 3'd7 && !in_final) begin
                    pend_next = 1'b1;
                    held_next = in_byte;
                end else begin
                    pend_next = 1'b0;
                    held_next = 8'h00;
                    grp_next.chars[grp_next.cnt[1:0]] = in_byte;
                    grp_next.cnt = grp_next.cnt + 4'd1;
                end
            end
            gv_next = grp_next.cnt != 4'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 1'b0;
            held_reg <= 8'h00;
            gv_reg   <= 1'b0;
        end else begin
            pend_reg <= pend_next;
            held_reg <= held_next;
            gv_reg   <= gv_next;
        end
        grp_reg <= grp_next;
    end
endmodule

FILE: rtl/u2a_serialize.sv
// u2a_serialize: drains a group of up to four letters one per word
// depends on u2a_pkg
module u2a_serialize (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             grp_valid,
    output logic             grp_ready,
    input  u2a_pkg::expand_t grp,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [7:0]       out_char,
    output logic             out_last
);
    import u2a_pkg::*;

    logic [1:0] idx_reg, idx_next;
    logic       last;

    assign last      = (4'({2'b00, idx_reg}) + 4'd1) == grp.cnt;
    assign out_valid = grp_valid;
    assign out_char  = grp.chars[idx_reg];
    assign out_last  = last;
    assign grp_ready = out_ready && last;

    always_comb begin
        idx_next = idx_reg;
        if (grp_valid && out_ready) begin
            idx_next = last ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= 2'd0;
        end else begin
            idx_reg <= idx_next;
        end
    end
endmodule

FILE: rtl/utf8_latin_greek_cyrillic_to_ascii.sv
// Transliterates a UTF-8 byte stream to ASCII. One byte is accepted per cycle
// while the output is not stalled; a byte that yields n output words holds the
// input while the output stage drains its letters, so throughput is one output
// word per cycle while m_tready is high, set by the single output register.
// depends on u2a_pkg, u2a_decode, u2a_serialize
module utf8_latin_greek_cyrillic_to_ascii (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // in_byte
    input  logic        s_tlast,   // in_final
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_char
    output logic        m_tlast    // out_last
);
    import u2a_pkg::*;

    logic    gv, gr;
    expand_t g;

    u2a_decode u_dec (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .in_byte(s_tdata), .in_final(s_tlast),
        .grp_valid(gv), .grp_ready(gr), .grp(g)
    );

    u2a_serialize u_ser (
        .aclk(aclk), .aresetn(aresetn),
        .grp_valid(gv), .grp_ready(gr), .grp(g),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .out_char(m_tdata), .out_last(m_tlast)
    );
endmodule

FILE: rtl/u2a_checker.sv
// u2a_checker: port level assertions for the transliteration block
// bound to utf8_latin_greek_cyrillic_to_ascii
module u2a_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output changed while stalled");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");
    a_mid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input taken mid expansion");
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");
endmodule

bind utf8_latin_greek_cyrillic_to_ascii u2a_checker u_chk (.*);

FILE: tb/tb_top.sv
// tb_top: self-checking bench for utf8_latin_greek_cyrillic_to_ascii
// drives utf-8 byte strings with random stalls and checks every output word
// against a built-in transliteration predictor; depends on the rtl only

class translit_board;
    bit [8:0] pending_words[$];
    bit       lead_held;
    bit [7:0] held_byte;
    int       errors;

    function new();
        lead_held = 0;
        held_byte = 8'h00;
        errors = 0;
    endfunction

    static function int slot_of(bit [7:0] b);
        case (b)
            8'hC3: return 0;
            8'hC4: return 1;
            8'hC5: return 2;
            8'hCE: return 3;
            8'hCF: return 4;
            8'hD0: return 5;
            8'hD1: return 6;
            default: return -1;
        endcase
    endfunction

    // -1 no entry, otherwise number of letters in txt
    static function int letters_for(bit [7:0] lead, bit [7:0] nxt, output string txt);
        string rows[7];
        int s;
        byte ch;
        rows[0] = "AAAAAA.CEEEEIIIIDNOOOOO.OUUUUY..aaaaaa.ceeeeiiiidnooooo.ouuuuy.y";
        rows[1] = "AaAaAaCcCcCcCcDdDdEeEeEeEeEeGgGgGgGgHhHhIiIiIiIiIi..JjKk.LlLlLl.";
        rows[2] = "LlLlNnNnNn.NnOoOoo..RrRrRrSsSsSsSsTtTtTtUuUuUuUuUuUuWwYyYZzZzZz.";
        rows[3] = ".................ABGDEZI.IKLMNXOPR.STYF..O.......abgdezi.iklmnxo";
        rows[4] = "prssty...o......................................................";
        rows[5] = "................ABVGDE.ZIIKLMNOPRSTUF......Y.E..abvgde.ziiklmnop";
        rows[6] = "rstuf......y.e..Ee..............................................";
        txt = "";
        s = slot_of(lead);
        if (s < 0 || nxt[7:6] != 2'b10) return -1;
        case ({lead, nxt})
            16'hC386: txt = "AE";   16'hC3A6: txt = "ae";   16'hC39F: txt = "ss";
            16'hC4B2: txt = "IJ";   16'hC4B3: txt = "ij";   16'hC592: txt = "OE";
            16'hC593: txt = "oe";   16'hD096: txt = "Zh";   16'hD0A5: txt = "Kh";
            16'hD0A6: txt = "Ts";   16'hD0A7: txt = "Ch";   16'hD0A8: txt = "Sh";
            16'hD0A9: txt = "Shch"; 16'hD0AE: txt = "Yu";   16'hD0AF: txt = "Ya";
            16'hD0B6: txt = "zh";   16'hD185: txt = "kh";   16'hD186: txt = "ts";
            16'hD187: txt = "ch";   16'hD188: txt = "sh";   16'hD189: txt = "shch";
            16'hD18E: txt = "yu";   16'hD18F: txt = "ya";   16'hCE98: txt = "Th";
            16'hCEA7: txt = "Ch";   16'hCEA8: txt = "Ps";   16'hCEB8: txt = "th";
            16'hCF86: txt = "ph";   16'hCF87: txt = "ch";   16'hCF88: txt = "ps";
            16'hD0AA, 16'hD0AC, 16'hD18A, 16'hD18C: return 0;
            default: begin
                ch = rows[s][nxt[5:0]];
                if (ch == ".") return -1;
                txt = string'(ch);
            end
        endcase
        return txt.len();
    endfunction

    function void note_byte(bit [7:0] b, bit fin);
        string txt;
        int r;
        bit [8:0] words[$];
        if (lead_held) begin
            r = letters_for(held_byte, b, txt);
            lead_held = 0;
            if (r >= 0) begin
                for (int k = 0; k < r; k++)
                    pending_words.push_back({k == r - 1, 8'(txt[k])});
                held_byte = 0;
                return;
            end
            words.push_back({1'b0, held_byte});
            held_byte = 0;
        end
        if (slot_of(b) >= 0 && !fin) begin
            lead_held = 1;
            held_byte = b;
        end else begin
            words.push_back({1'b0, b});
        end
        if (words.size() > 0) words[words.size() - 1][8] = 1'b1;
        foreach (words[i]) pending_words.push_back(words[i]);
    endfunction

    task report_mismatch(string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    task check_word(bit [7:0] c, bit last);
        bit [8:0] e;
        if (pending_words.size() == 0) begin
            report_mismatch($sformatf("unexpected word %h last %b", c, last));
            return;
        end
        e = pending_words.pop_front();
        if (e[7:0] !== c)
            report_mismatch($sformatf("char got %h want %h", c, e[7:0]));
        if (e[8] !== last)
            report_mismatch($sformatf("last got %b want %b on %h", last, e[8], c));
    endtask
endclass

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IdleLimit = 2000;

    logic       aclk = 0;
    logic       aresetn = 0;
    logic       s_tvalid = 0;
    logic       s_tready;
    logic [7:0] s_tdata = 0;
    logic       s_tlast = 0;
    logic       m_tvalid;
    logic       m_tready = 0;
    logic [7:0] m_tdata;
    logic       m_tlast;

    translit_board board = new();
    int src_idle_pct = 28;
    int dst_idle_pct = 86;
    int quiet_cycles = 0;
    bit timed_out = 0;

    utf8_latin_greek_cyrillic_to_ascii dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) board.check_word(m_tdata, m_tlast);
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            m_tready <= ($urandom_range(99) >= dst_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (quiet_cycles >= IdleLimit && !timed_out) begin
            timed_out = 1;
            $display("utf8_latin_greek_cyrillic_to_ascii regression: fail");
            $finish;
        end
    end

    task automatic send_word(bit [7:0] b, bit fin);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata  <= b;
        s_tlast  <= fin;
        @(negedge aclk);
        while (!s_tready) @(negedge aclk);
        @(posedge aclk);
        board.note_byte(b, fin);
    endtask

    task automatic send_string(bit [7:0] bytes[$]);
        foreach (bytes[i]) send_word(bytes[i], i == bytes.size() - 1);
    endtask

    function automatic bit [7:0] any_lead();
        bit [7:0] leads[7] = '{8'hC3, 8'hC4, 8'hC5, 8'hCE, 8'hCF, 8'hD0, 8'hD1};
        return leads[$urandom_range(6)];
    endfunction

    task automatic random_string();
        bit [7:0] s[$];
        int len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++) begin
            case ($urandom_range(9))
                0, 1, 2, 3, 4, 5: begin
                    s.push_back(any_lead());
                    s.push_back(8'($urandom_range(8'h80, 8'hBF)));
                end
                6: s.push_back(any_lead());
                7: s.push_back(8'($urandom_range(0, 127)));
                default: s.push_back(8'($urandom));
            endcase
        end
        send_string(s);
    endtask

    task automatic drain();
        while (board.pending_words.size() > 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1;
        // directed: extremes, drop signs, long expansions, unmatched pairs, lead on last
        send_string('{8'h00});
        send_string('{8'hFF});
        send_string('{8'hD0, 8'hA9, 8'hD1, 8'h89});
        send_string('{8'hD0, 8'hAA, 8'hD0, 8'hAC, 8'hD1, 8'h8A, 8'hD1, 8'h8C});
        send_string('{8'hC3, 8'h86, 8'hC5, 8'h91, 8'hD1, 8'h90});
        send_string('{8'hC4, 8'hB9, 8'hC4, 8'hBE, 8'hCF, 8'hBF});
        send_string('{8'hC3, 8'hD1});
        send_string('{8'hCE, 8'h41, 8'hC5});
        send_string('{8'hC3, 8'hC0});
        for (int ph = 0; ph < 3; ph++) begin
            src_idle_pct = (ph == 0) ? 28 : (ph == 1) ? 86 : 0;
            dst_idle_pct = (ph == 0) ? 86 : (ph == 1) ? 28 : 0;
            repeat (18) random_string();
        end
        s_tvalid <= 0;
        drain();
        if (board.errors == 0 && board.pending_words.size() == 0)
            $display("utf8_latin_greek_cyrillic_to_ascii regression: pass");
        else
            $display("utf8_latin_greek_cyrillic_to_ascii regression: fail");
        $finish;
    end
endmodule
